// ===== rtl/core/pet_pkg.sv =====
// ----------------------------------------------------------------------------
// pet_pkg
// Shared types, event codes and helpers for the pointer event tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package pet_pkg;

  localparam int SCREEN_BITS = 12;
  localparam int SIZE_W      = SCREEN_BITS + 1;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = SIZE_W;
  localparam int TABLET_W    = 15;
  localparam int PROD_W      = TABLET_W + SCREEN_BITS;
  localparam int SUM_W       = 34;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [TABLET_W-1:0] TABLET_MAX = 15'h7FFF;

  localparam logic        OP_EVENT = 1'b0;
  localparam logic        OP_INIT  = 1'b1;

  localparam logic [15:0] EVT_KEY    = 16'h0001;
  localparam logic [15:0] EVT_REL    = 16'h0002;
  localparam logic [15:0] EVT_ABS    = 16'h0003;
  localparam logic [15:0] BTN_CODE_L = 16'h0110;
  localparam logic [15:0] BTN_CODE_R = 16'h0111;
  localparam logic [15:0] BTN_CODE_M = 16'h0112;
  localparam logic [15:0] AXIS_X     = 16'h0000;
  localparam logic [15:0] AXIS_Y     = 16'h0001;

  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [SIZE_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = 13'd480;
  localparam logic [SIZE_W-1:0] SIZE_TOP     = SIZE_W'(1 << SCREEN_BITS);

  typedef enum logic [2:0] {
    KIND_NOP,
    KIND_INIT,
    KIND_KEY,
    KIND_BUTTON,
    KIND_REL,
    KIND_ABS
  } pet_kind_t;

  typedef struct packed {
    logic               opcode;
    logic [15:0]        event_type;
    logic [15:0]        event_code;
    logic signed [31:0] event_value;
  } pet_in_t;

  typedef struct packed {
    logic [SCREEN_BITS-1:0] cursor_x;
    logic [SCREEN_BITS-1:0] cursor_y;
    logic [2:0]             button_bits;
    logic [15:0]            key_code;
    logic signed [31:0]     key_value;
    logic                   key_pending;
  } pet_out_t;

  typedef struct packed {
    pet_kind_t          kind;
    logic               axis_x;
    logic               axis_y;
    logic [2:0]         btn_mask;
    logic               btn_set;
    logic [15:0]        code;
    logic signed [31:0] value;
    logic               abs_direct;
    logic [PROD_W-1:0]  abs_prod;
  } pet_cmd_t;

  // zero acts as one, oversize clamps to the full screen
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] reg_val);
    logic [SIZE_W-1:0] res;
    res = reg_val;
    if (reg_val == '0) begin
      res = SIZE_W'(1);
    end else if (reg_val > SIZE_TOP) begin
      res = SIZE_TOP;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pet_front.sv =====
// ----------------------------------------------------------------------------
// pet_front
// Accepts input words, decodes them into commands and precomputes the
// absolute-position product. One register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pet_front
  import pet_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pet_in_t           in_data,
  input  wire logic [SIZE_W-1:0] scr_w,
  input  wire logic [SIZE_W-1:0] scr_h,
  output logic                   cmd_valid,
  input  wire logic              cmd_ready,
  output pet_cmd_t               cmd
);

  logic                     vld_r;
  logic                     vld_nxt;
  pet_cmd_t                 cmd_r;
  pet_cmd_t                 cmd_nxt;
  logic                     in_fire;
  logic [SIZE_W-1:0]        size;
  logic [SCREEN_BITS-1:0]   size_m1;
  logic [TABLET_W-1:0]      clamp_v;
  logic [2:0]               mask;

  assign in_ready  = !vld_r || cmd_ready;
  assign in_fire   = in_valid && in_ready;
  assign cmd_valid = vld_r;
  assign cmd       = cmd_r;

  always_comb begin
    size    = (in_data.event_code == AXIS_Y) ? scr_h : scr_w;
    size_m1 = SCREEN_BITS'(size - SIZE_W'(1));

    if (in_data.event_value[31]) begin
      clamp_v = '0;
    end else if (|in_data.event_value[30:TABLET_W]) begin
      clamp_v = TABLET_MAX;
    end else begin
      clamp_v = in_data.event_value[TABLET_W-1:0];
    end

    case (in_data.event_code)
      BTN_CODE_L: mask = 3'b001;
      BTN_CODE_R: mask = 3'b010;
      BTN_CODE_M: mask = 3'b100;
      default:    mask = 3'b000;
    endcase

    cmd_nxt            = '0;
    cmd_nxt.axis_x     = (in_data.event_code == AXIS_X);
    cmd_nxt.axis_y     = (in_data.event_code == AXIS_Y);
    cmd_nxt.btn_mask   = mask;
    cmd_nxt.btn_set    = |in_data.event_value;
    cmd_nxt.code       = in_data.event_code;
    cmd_nxt.value      = in_data.event_value;
    cmd_nxt.abs_direct = !in_data.event_value[31]
                         && ($unsigned(in_data.event_value) < 32'(size));
    cmd_nxt.abs_prod   = PROD_W'(clamp_v) * PROD_W'(size_m1);

    if (in_data.opcode == OP_INIT) begin
      cmd_nxt.kind = KIND_INIT;
    end else begin
      unique case (in_data.event_type)
        EVT_KEY: cmd_nxt.kind = (mask != 3'b000) ? KIND_BUTTON : KIND_KEY;
        EVT_REL: cmd_nxt.kind = KIND_REL;
        EVT_ABS: cmd_nxt.kind = KIND_ABS;
        default: cmd_nxt.kind = KIND_NOP;
      endcase
    end

    vld_nxt = in_fire || (vld_r && !cmd_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pet_queue.sv =====
// ----------------------------------------------------------------------------
// pet_queue
// Small command FIFO between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module pet_queue
  import pet_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
)(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr_valid,
  output logic          wr_ready,
  input  wire pet_cmd_t wr_data,
  output logic          rd_valid,
  input  wire logic     rd_ready,
  output pet_cmd_t      rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pet_cmd_t           mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic               wr_fire;
  logic               rd_fire;

  assign wr_ready = (cnt_r != CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_fire) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (rd_fire) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (wr_fire && !rd_fire) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (rd_fire && !wr_fire) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pet_back.sv =====
// ----------------------------------------------------------------------------
// pet_back
// Executes commands against the cursor, button and key state; the state
// registers drive the result word directly.
// ----------------------------------------------------------------------------
`default_nettype none

module pet_back
  import pet_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cmd_valid,
  output logic                   cmd_ready,
  input  wire pet_cmd_t          cmd,
  input  wire logic [SIZE_W-1:0] scr_w,
  input  wire logic [SIZE_W-1:0] scr_h,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pet_out_t               out_data
);

  logic                    out_vld_r;
  logic                    out_vld_nxt;
  logic [SCREEN_BITS-1:0]  col_r, col_nxt;
  logic [SCREEN_BITS-1:0]  row_r, row_nxt;
  logic [2:0]              btn_r, btn_nxt;
  logic [15:0]             kcode_r, kcode_nxt;
  logic signed [31:0]      kval_r, kval_nxt;
  logic                    kseen_r, kseen_nxt;
  logic                    cmd_fire;
  logic [SCREEN_BITS-1:0]  q0;
  logic [TABLET_W:0]       rem;
  logic [SCREEN_BITS-1:0]  quot;
  logic [SCREEN_BITS-1:0]  abs_pos;
  logic signed [SUM_W-1:0] val_ext;
  logic signed [SUM_W-1:0] base_x, base_y;
  logic signed [SUM_W-1:0] tgt_x, tgt_y;

  function automatic logic [SCREEN_BITS-1:0] sat_axis(
    input logic signed [SUM_W-1:0] v,
    input logic [SIZE_W-1:0]       size
  );
    logic [SIZE_W-1:0]       top;
    logic [SCREEN_BITS-1:0]  res;
    top = size - SIZE_W'(1);
    if (v < 0) begin
      res = '0;
    end else if (v > $signed(SUM_W'(top))) begin
      res = top[SCREEN_BITS-1:0];
    end else begin
      res = v[SCREEN_BITS-1:0];
    end
    return res;
  endfunction

  assign cmd_ready = !out_vld_r || out_ready;
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign out_valid = out_vld_r;

  assign out_data.cursor_x    = col_r;
  assign out_data.cursor_y    = row_r;
  assign out_data.button_bits = btn_r;
  assign out_data.key_code    = kcode_r;
  assign out_data.key_value   = kval_r;
  assign out_data.key_pending = kseen_r;

  always_comb begin
    // divide by 2^15-1: q0 = p >> 15, remainder q0 + low bits, one correction
    q0      = cmd.abs_prod[PROD_W-1:TABLET_W];
    rem     = {1'b0, cmd.abs_prod[TABLET_W-1:0]} + (TABLET_W+1)'(q0);
    quot    = q0 + SCREEN_BITS'(rem >= (TABLET_W+1)'(TABLET_MAX));
    abs_pos = cmd.abs_direct ? cmd.value[SCREEN_BITS-1:0] : quot;

    val_ext = SUM_W'(cmd.value);
    base_x  = $signed(SUM_W'(col_r));
    base_y  = $signed(SUM_W'(row_r));
    tgt_x   = base_x;
    tgt_y   = base_y;
    if (cmd.kind == KIND_REL) begin
      if (cmd.axis_x) tgt_x = base_x + val_ext;
      if (cmd.axis_y) tgt_y = base_y + val_ext;
    end else begin
      if (cmd.axis_x) tgt_x = $signed(SUM_W'(abs_pos));
      if (cmd.axis_y) tgt_y = $signed(SUM_W'(abs_pos));
    end

    col_nxt   = col_r;
    row_nxt   = row_r;
    btn_nxt   = btn_r;
    kcode_nxt = kcode_r;
    kval_nxt  = kval_r;
    kseen_nxt = kseen_r;

    if (cmd_fire) begin
      unique case (cmd.kind) inside
        KIND_INIT: begin
          col_nxt   = scr_w[SIZE_W-1:1];
          row_nxt   = scr_h[SIZE_W-1:1];
          btn_nxt   = '0;
          kcode_nxt = '0;
          kval_nxt  = '0;
          kseen_nxt = 1'b0;
        end
        KIND_KEY: begin
          kcode_nxt = cmd.code;
          kval_nxt  = cmd.value;
          kseen_nxt = 1'b1;
        end
        KIND_BUTTON: begin
          btn_nxt = cmd.btn_set ? (btn_r | cmd.btn_mask) : (btn_r & ~cmd.btn_mask);
        end
        KIND_REL, KIND_ABS: begin
          col_nxt = sat_axis(tgt_x, scr_w);
          row_nxt = sat_axis(tgt_y, scr_h);
        end
        default: begin
        end
      endcase
    end

    out_vld_nxt = cmd_fire || (out_vld_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      col_r     <= RESET_WIDTH[SIZE_W-1:1];
      row_r     <= RESET_HEIGHT[SIZE_W-1:1];
      btn_r     <= '0;
      kcode_r   <= '0;
      kval_r    <= '0;
      kseen_r   <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      btn_r     <= btn_nxt;
      kcode_r   <= kcode_nxt;
      kval_r    <= kval_nxt;
      kseen_r   <= kseen_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pointer_event_tracker_core.sv =====
// Path: front register, command queue, then the back-end state registers.
// Throughput: one word per cycle while the output is not stalled; set by the front
// register, the command queue and the state update in the back end.
// Reset (synchronous): screen 640x480, cursor centered at (320, 240),
// buttons, key code, key value and key flag cleared, queue empty.
// ----------------------------------------------------------------------------
// pointer_event_tracker_core
// Cursor, button and key tracker for evdev-style input words.
// ----------------------------------------------------------------------------
`default_nettype none

module pointer_event_tracker_core
  import pet_pkg::*;
#(
  parameter int QUEUE_DEPTH = pet_pkg::QUEUE_DEPTH
)(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire pet_in_t                in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output pet_out_t                    out_data,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic [SIZE_W-1:0] scr_w_r;
  logic [SIZE_W-1:0] scr_h_r;
  logic [SIZE_W-1:0] eff_w;
  logic [SIZE_W-1:0] eff_h;
  logic              fq_valid, fq_ready;
  pet_cmd_t          fq_cmd;
  logic              qb_valid, qb_ready;
  pet_cmd_t          qb_cmd;

  assign eff_w = eff_size(scr_w_r);
  assign eff_h = eff_size(scr_h_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= RESET_WIDTH;
      scr_h_r <= RESET_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  scr_w_r <= cfg_wdata;
        REG_SCREEN_HEIGHT: scr_h_r <= cfg_wdata;
      endcase
    end
  end

  pet_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .scr_w     (eff_w),
    .scr_h     (eff_h),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd       (fq_cmd)
  );

  pet_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_cmd),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_cmd)
  );

  pet_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (qb_valid),
    .cmd_ready (qb_ready),
    .cmd       (qb_cmd),
    .scr_w     (eff_w),
    .scr_h     (eff_h),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/core/pet_checker.sv =====
// ----------------------------------------------------------------------------
// pet_checker
// Port-level checks for the pointer event tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pet_checker
  import pet_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire pet_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_key_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.key_pending |-> out_data.key_code == '0
                                            && out_data.key_value == '0)
    else $error("key fields set without key flag");

endmodule

bind pointer_event_tracker_core pet_checker u_pet_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== verif/pointer_event_tracker_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pointer_event_tracker_core_test
// Self-checking bench for the cursor/button/key tracker. Directed words cover
// buttons, keys, relative and absolute moves, init and screen size limits;
// then a random stream over several screen sizes with random idling on both
// sides. A local tracker model predicts each output word.
// ----------------------------------------------------------------------------

module pointer_event_tracker_core_test;
  import pet_pkg::*;

  localparam int          CYCLE_LIMIT  = 300000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          PHASES       = 6;
  localparam int          PHASE_WORDS  = 75;
  localparam int          PRINT_MAX    = 20;
  localparam logic [2:0]  LEFT_BIT     = 3'b001;
  localparam logic [2:0]  RIGHT_BIT    = 3'b010;
  localparam logic [2:0]  MIDDLE_BIT   = 3'b100;
  localparam longint      TABLET_TOP   = 32767;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  pet_in_t                in_data;
  logic                   out_valid;
  logic                   out_ready;
  pet_out_t               out_data;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  int unsigned cycle_count;
  int unsigned mismatch_count;
  bit          src_fast;
  bit          sink_fast;
  pet_out_t    expected_state_q[$];

  logic [SIZE_W-1:0]      scr_w;
  logic [SIZE_W-1:0]      scr_h;
  logic [SCREEN_BITS-1:0] trk_col;
  logic [SCREEN_BITS-1:0] trk_row;
  logic [2:0]             trk_btn;
  logic [15:0]            trk_kcode;
  logic [31:0]            trk_kval;
  logic                   trk_kseen;

  pointer_event_tracker_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------- tracker model ----------------

  function automatic longint screen_span(input logic [SIZE_W-1:0] r);
    if (r == '0) return 1;
    if (r > 13'd4096) return 4096;
    return longint'(r);
  endfunction

  function automatic logic [SCREEN_BITS-1:0] clamp_axis(input longint v, input longint span);
    if (v < 0) return '0;
    if (v > span - 1) return SCREEN_BITS'(span - 1);
    return SCREEN_BITS'(v);
  endfunction

  function automatic longint tablet_place(input longint v, input longint span);
    longint t;
    t = v;
    if (t >= 0 && t < span) return t;
    if (t < 0) t = 0;
    if (t > TABLET_TOP) t = TABLET_TOP;
    return (t * (span - 1)) / TABLET_TOP;
  endfunction

  function automatic void recenter_tracker();
    trk_col   = SCREEN_BITS'(screen_span(scr_w) / 2);
    trk_row   = SCREEN_BITS'(screen_span(scr_h) / 2);
    trk_btn   = '0;
    trk_kcode = '0;
    trk_kval  = '0;
    trk_kseen = 1'b0;
  endfunction

  function automatic pet_out_t track_event(input pet_in_t w);
    longint     span_w;
    longint     span_h;
    longint     x;
    longint     y;
    longint     val;
    logic [2:0] bit_sel;
    pet_out_t   r;
    span_w = screen_span(scr_w);
    span_h = screen_span(scr_h);
    val    = longint'($signed(w.event_value));
    if (w.opcode == OP_INIT) begin
      recenter_tracker();
    end else if (w.event_type == EVT_KEY) begin
      case (w.event_code)
        BTN_CODE_L: bit_sel = LEFT_BIT;
        BTN_CODE_R: bit_sel = RIGHT_BIT;
        BTN_CODE_M: bit_sel = MIDDLE_BIT;
        default:    bit_sel = '0;
      endcase
      if (bit_sel != '0) begin
        if (w.event_value != '0) begin
          trk_btn = trk_btn | bit_sel;
        end else begin
          trk_btn = trk_btn & ~bit_sel;
        end
      end else begin
        trk_kcode = w.event_code;
        trk_kval  = w.event_value;
        trk_kseen = 1'b1;
      end
    end else if (w.event_type == EVT_REL || w.event_type == EVT_ABS) begin
      x = longint'(trk_col);
      y = longint'(trk_row);
      if (w.event_type == EVT_REL) begin
        if (w.event_code == AXIS_X) x = x + val;
        if (w.event_code == AXIS_Y) y = y + val;
      end else begin
        if (w.event_code == AXIS_X) x = tablet_place(val, span_w);
        if (w.event_code == AXIS_Y) y = tablet_place(val, span_h);
      end
      trk_col = clamp_axis(x, span_w);
      trk_row = clamp_axis(y, span_h);
    end
    r.cursor_x    = trk_col;
    r.cursor_y    = trk_row;
    r.button_bits = trk_btn;
    r.key_code    = trk_kcode;
    r.key_value   = trk_kval;
    r.key_pending = trk_kseen;
    return r;
  endfunction

  // ---------------- drivers ----------------

  function automatic pet_in_t make_event(input logic op, input logic [15:0] etype,
                                         input logic [15:0] ecode, input logic [31:0] eval);
    pet_in_t w;
    w.opcode      = op;
    w.event_type  = etype;
    w.event_code  = ecode;
    w.event_value = eval;
    return w;
  endfunction

  task automatic send_word(input pet_in_t w);
    int unsigned gap;
    gap = src_fast ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_state_q.push_back(track_event(w));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_state_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_screen(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= REG_SCREEN_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    scr_w = w;
    scr_h = h;
    @(posedge clk);
  endtask

  initial begin : sink
    int unsigned stall;
    out_ready <= 1'b0;
    forever begin
      stall = sink_fast ? 0 : $urandom_range(0, 12);
      repeat (stall) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  // ---------------- checker ----------------

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_MAX) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check
    pet_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_state_q.size() == 0) begin
        report_mismatch("output word with nothing expected");
      end else begin
        want = expected_state_q.pop_front();
        if (out_data.cursor_x !== want.cursor_x)
          report_mismatch($sformatf("cursor_x %0d, want %0d", out_data.cursor_x, want.cursor_x));
        if (out_data.cursor_y !== want.cursor_y)
          report_mismatch($sformatf("cursor_y %0d, want %0d", out_data.cursor_y, want.cursor_y));
        if (out_data.button_bits !== want.button_bits)
          report_mismatch($sformatf("button_bits %b, want %b",
                                    out_data.button_bits, want.button_bits));
        if (out_data.key_code !== want.key_code)
          report_mismatch($sformatf("key_code %h, want %h", out_data.key_code, want.key_code));
        if (out_data.key_value !== want.key_value)
          report_mismatch($sformatf("key_value %h, want %h", out_data.key_value, want.key_value));
        if (out_data.key_pending !== want.key_pending)
          report_mismatch($sformatf("key_pending %b, want %b",
                                    out_data.key_pending, want.key_pending));
      end
    end
  end

  // ---------------- tests ----------------

  task automatic test_idle_types();
    send_word(make_event(OP_EVENT, 16'h0000, 16'h0000, 32'h0000_0000));
    send_word(make_event(OP_EVENT, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
  endtask

  task automatic test_buttons();
    send_word(make_event(OP_EVENT, EVT_KEY, BTN_CODE_L, 32'h0000_0001));
    send_word(make_event(OP_EVENT, EVT_KEY, BTN_CODE_R, 32'hFFFF_FFFF));
    send_word(make_event(OP_EVENT, EVT_KEY, BTN_CODE_M, 32'h8000_0000));
    send_word(make_event(OP_EVENT, EVT_KEY, BTN_CODE_R, 32'h0000_0000));
    send_word(make_event(OP_EVENT, EVT_KEY, BTN_CODE_L, 32'h0000_0000));
  endtask

  task automatic test_keys();
    send_word(make_event(OP_EVENT, EVT_KEY, 16'h001E, 32'h0000_0001));
    send_word(make_event(OP_EVENT, EVT_KEY, 16'hFFFF, 32'h7FFF_FFFF));
    send_word(make_event(OP_EVENT, EVT_KEY, 16'h0000, 32'h0000_0000));
  endtask

  task automatic test_relative();
    send_word(make_event(OP_EVENT, EVT_REL, AXIS_X, 32'd100));
    send_word(make_event(OP_EVENT, EVT_REL, AXIS_Y, 32'h8000_0000));
    send_word(make_event(OP_EVENT, EVT_REL, AXIS_X, 32'h7FFF_FFFF));
    send_word(make_event(OP_EVENT, EVT_REL, 16'h0002, 32'd5));
  endtask

  task automatic test_absolute();
    send_word(make_event(OP_EVENT, EVT_ABS, AXIS_X, 32'd100));
    send_word(make_event(OP_EVENT, EVT_ABS, AXIS_Y, 32'd32767));
    send_word(make_event(OP_EVENT, EVT_ABS, AXIS_X, 32'hFFFF_FFFF));
    send_word(make_event(OP_EVENT, EVT_ABS, AXIS_Y, 32'h7FFF_FFFF));
    send_word(make_event(OP_EVENT, EVT_ABS, 16'hFFFF, 32'd7));
  endtask

  task automatic test_init();
    send_word(make_event(OP_INIT, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
  endtask

  task automatic test_screen_limits();
    set_screen(13'd0, 13'd0);
    send_word(make_event(OP_INIT, EVT_ABS, AXIS_X, 32'd0));
    send_word(make_event(OP_EVENT, EVT_ABS, AXIS_X, 32'd32767));
    set_screen(13'h1FFF, 13'd4097);
    send_word(make_event(OP_INIT, EVT_KEY, BTN_CODE_L, 32'd1));
    send_word(make_event(OP_EVENT, EVT_ABS, AXIS_X, 32'd32767));
  endtask

  task automatic test_screen_shrink();
    set_screen(13'd4096, 13'd1);
    send_word(make_event(OP_EVENT, EVT_ABS, AXIS_X, 32'd1000));
    set_screen(13'd100, 13'd100);
    send_word(make_event(OP_EVENT, EVT_KEY, 16'h0041, 32'd2));
    send_word(make_event(OP_EVENT, EVT_REL, 16'h0005, 32'd0));
  endtask

  function automatic pet_in_t random_event();
    pet_in_t     w;
    int unsigned sel;
    int unsigned pick;
    w   = make_event(OP_EVENT, 16'($urandom), 16'($urandom), $urandom);
    sel = $urandom_range(0, 99);
    pick = $urandom_range(0, 9);
    if (sel < 5) begin
      w.opcode = OP_INIT;
    end else if (sel < 25) begin
      w.event_type = EVT_KEY;
      if (pick < 6) w.event_code = BTN_CODE_L + 16'($urandom_range(0, 2));
      case ($urandom_range(0, 3))
        0:       w.event_value = '0;
        1:       w.event_value = 32'd1;
        2:       w.event_value = 32'd2;
        default: ;
      endcase
    end else if (sel < 90) begin
      w.event_type = (sel < 60) ? EVT_REL : EVT_ABS;
      if (pick < 9) w.event_code = 16'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      if (w.event_type == EVT_REL) begin
        if (pick < 8) w.event_value = 32'($urandom_range(0, 400)) - 32'd200;
        else if (pick == 8) begin
          case ($urandom_range(0, 2))
            0:       w.event_value = 32'h8000_0000;
            1:       w.event_value = 32'h7FFF_FFFF;
            default: w.event_value = 32'hFFFF_FFFF;
          endcase
        end
      end else begin
        if (pick < 4) begin
          w.event_value = 32'($urandom_range(0, int'(screen_span(
                            w.event_code == AXIS_Y ? scr_h : scr_w)) - 1));
        end else if (pick < 8) begin
          w.event_value = 32'($urandom_range(0, 32767));
        end
      end
    end else begin
      w.opcode = 1'($urandom);
    end
    return w;
  endfunction

  task automatic test_random_stream();
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       set_screen(13'd640, 13'd480);
        1:       set_screen(13'd1, 13'd1);
        2:       set_screen(13'd4096, 13'd4096);
        3:       set_screen(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)));
        4:       set_screen(13'($urandom_range(1, 64)), 13'($urandom_range(1, 64)));
        default: set_screen(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
      endcase
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (i % 25 == 0) begin
          src_fast  = ($urandom_range(0, 2) == 0);
          sink_fast = ($urandom_range(0, 2) == 0);
        end
        if ($urandom_range(0, 59) == 0) wait_drained();
        send_word(random_event());
      end
    end
    src_fast  = 1'b0;
    sink_fast = 1'b0;
  endtask

  initial begin
    cycle_count    = 0;
    mismatch_count = 0;
    src_fast       = 1'b0;
    sink_fast      = 1'b0;
    scr_w          = RESET_WIDTH;
    scr_h          = RESET_HEIGHT;
    recenter_tracker();
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_types();
    test_buttons();
    test_keys();
    test_relative();
    test_absolute();
    test_init();
    test_screen_limits();
    test_screen_shrink();
    test_random_stream();
    wait_drained();

    if (mismatch_count == 0 && expected_state_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== pointer_event_tracker_core.f =====
rtl/core/pet_pkg.sv
rtl/core/pet_front.sv
rtl/core/pet_queue.sv
rtl/core/pet_back.sv
rtl/core/pointer_event_tracker_core.sv
rtl/core/pet_checker.sv
verif/pointer_event_tracker_core_test.sv
